// File: src/cfr_pkg.sv
package cfr_pkg;

    // CRC-16/CCITT-FALSE constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Length of an info frame: command word, one payload byte, CRC.
    localparam int SHORT_FRAME = 2 + 1 + 2;

    // Result status codes.
    localparam logic [2:0] STS_INCOMPLETE = 3'd0;
    localparam logic [2:0] STS_KEY        = 3'd1;
    localparam logic [2:0] STS_CHALLENGE  = 3'd2;
    localparam logic [2:0] STS_INFO       = 3'd3;
    localparam logic [2:0] STS_UNKNOWN    = 3'd4;
    localparam logic [2:0] STS_CRC_ERROR  = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PUBLIC_KEY = 2'd0;
    localparam logic [1:0] CFG_CHALLENGE  = 2'd1;
    localparam logic [1:0] CFG_INFO       = 2'd2;

    // Request from the sequencer to the CRC shifter.
    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] data;
    } t_crc_req;

    // Status returned by the CRC shifter.
    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } t_crc_rsp;

endpackage

// File: src/cfr_crc_unit.sv
module cfr_crc_unit
    import cfr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_crc_req i_req,
    output t_crc_rsp o_rsp
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [3:0]  r_bits;
    logic [3:0]  n_bits;

    // A start folds the byte into the top of the register; after it,
    // each cycle shifts one bit of the byte through the polynomial.
    always_comb begin
        n_crc  = r_crc;
        n_bits = r_bits;
        priority if (i_req.clear) begin
            n_crc  = CRC_INIT;
            n_bits = 4'd0;
        end else if (i_req.start) begin
            n_crc  = r_crc ^ {i_req.data, 8'h00};
            n_bits = 4'd8;
        end else if (r_bits != 4'd0) begin
            if (r_crc[15]) begin
                n_crc = {r_crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                n_crc = {r_crc[14:0], 1'b0};
            end
            n_bits = r_bits - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_bits <= 4'd0;
        end else begin
            r_crc  <= n_crc;
            r_bits <= n_bits;
        end
    end

    assign o_rsp.busy = (r_bits != 4'd0);
    assign o_rsp.crc  = r_crc;

endmodule

// File: src/command_frame_receiver_crc16.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_data_byte
// result    out        o_valid / i_stall  o_status, o_payload_byte, o_last
// config    in         i_cfg_we           i_cfg_index, i_cfg_wdata
//
// A CRC-fed byte is answered once the shifter has loaded it, shifted all its bits and
// been seen idle. The low CRC byte, a final byte with no release and a rejected command
// are answered without waiting on the shifter.
// Each byte of a released payload run takes a registered memory read, then the result.
// Reset is synchronous; the payload store is not cleared.
// Input is stalled while a request is in work or its result is unaccepted.
module command_frame_receiver_crc16
    import cfr_pkg::*;
#(
    parameter int KEY_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    localparam int CW = $clog2(KEY_BYTES + 5);
    localparam int IW = $clog2(KEY_BYTES);
    localparam logic [CW-1:0] LONG_LEN  = CW'(KEY_BYTES + 4);
    localparam logic [CW-1:0] SHORT_LEN = CW'(SHORT_FRAME);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_len;
    logic [CW-1:0] n_len;
    logic [15:0]   r_cmd;
    logic [15:0]   n_cmd;
    logic [7:0]    r_crc_low;
    logic [7:0]    n_crc_low;
    logic [2:0]    r_out_status;
    logic [2:0]    n_out_status;
    logic          r_out_last;
    logic          n_out_last;
    logic [7:0]    r_out_payload;
    logic          r_release;
    logic          n_release;
    logic [IW-1:0] r_rd_idx;
    logic [IW-1:0] n_rd_idx;
    logic [15:0]   r_cfg_key;
    logic [15:0]   r_cfg_chal;
    logic [15:0]   r_cfg_info;
    logic [7:0]    r_mem [KEY_BYTES];

    logic          w_accept;
    logic          w_mem_we;
    logic [IW-1:0] w_wr_idx;
    logic [CW:0]   w_count_2;
    logic [15:0]   w_cmd_full;
    logic [15:0]   w_got;
    logic          w_long;
    t_crc_req      w_crc_req;
    t_crc_rsp      w_crc_rsp;

    cfr_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_crc_req),
        .o_rsp   (w_crc_rsp)
    );

    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_count_2  = {1'b0, r_count} + (CW + 1)'(2);
    assign w_wr_idx   = IW'(r_count - CW'(2));
    assign w_cmd_full = {i_data_byte, r_cmd[7:0]};
    assign w_got      = {i_data_byte, r_crc_low};
    assign w_long     = (r_len == LONG_LEN);

    // Frame sequencer: one accepted byte at a time.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_len         = r_len;
        n_cmd         = r_cmd;
        n_crc_low     = r_crc_low;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;
        n_release     = r_release;
        n_rd_idx      = r_rd_idx;
        w_mem_we      = 1'b0;
        w_crc_req     = '0;
        w_crc_req.data = i_data_byte;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_status = STS_INCOMPLETE;
                    n_out_last   = 1'b1;
                    n_release    = 1'b0;
                    n_state      = ST_SEND;
                    if (r_len == '0) begin
                        if (r_count == '0) begin
                            // First byte: low half of the command word.
                            n_cmd           = {8'h00, i_data_byte};
                            n_count         = CW'(1);
                            w_crc_req.start = 1'b1;
                            n_state         = ST_CRC;
                        end else if (w_cmd_full == r_cfg_key || w_cmd_full == r_cfg_chal) begin
                            n_cmd           = w_cmd_full;
                            n_len           = LONG_LEN;
                            n_count         = CW'(2);
                            w_crc_req.start = 1'b1;
                            n_state         = ST_CRC;
                        end else if (w_cmd_full == r_cfg_info) begin
                            n_cmd           = w_cmd_full;
                            n_len           = SHORT_LEN;
                            n_count         = CW'(2);
                            w_crc_req.start = 1'b1;
                            n_state         = ST_CRC;
                        end else begin
                            // Unknown command ends the frame at once.
                            n_cmd           = '0;
                            n_count         = '0;
                            n_crc_low       = '0;
                            w_crc_req.clear = 1'b1;
                            n_out_status    = STS_UNKNOWN;
                        end
                    end else if (w_count_2 < {1'b0, r_len}) begin
                        // Payload byte: store it and feed the CRC.
                        w_mem_we        = 1'b1;
                        n_count         = r_count + CW'(1);
                        w_crc_req.start = 1'b1;
                        n_state         = ST_CRC;
                    end else if (w_count_2 == {1'b0, r_len}) begin
                        n_crc_low = i_data_byte;
                        n_count   = r_count + CW'(1);
                    end else begin
                        // Last byte: check the CRC and judge the command.
                        n_cmd           = '0;
                        n_count         = '0;
                        n_len           = '0;
                        n_crc_low       = '0;
                        w_crc_req.clear = 1'b1;
                        priority if (w_got != w_crc_rsp.crc) begin
                            n_out_status = STS_CRC_ERROR;
                        end else if (w_long && r_cmd == r_cfg_key) begin
                            n_out_status = STS_KEY;
                            n_release    = 1'b1;
                        end else if (w_long && r_cmd == r_cfg_chal) begin
                            n_out_status = STS_CHALLENGE;
                            n_release    = 1'b1;
                        end else if (r_cmd == r_cfg_info) begin
                            n_out_status = STS_INFO;
                        end else begin
                            n_out_status = STS_UNKNOWN;
                        end
                        if (n_release) begin
                            n_rd_idx = '0;
                            n_state  = ST_READ;
                        end
                    end
                end
            end
            ST_CRC: begin
                if (!w_crc_rsp.busy) begin
                    n_state = ST_SEND;
                end
            end
            ST_READ: begin
                n_out_last = (r_rd_idx == IW'(KEY_BYTES - 1));
                n_state    = ST_SEND;
            end
            ST_SEND: begin
                if (!i_stall) begin
                    if (r_release && !r_out_last) begin
                        n_rd_idx = r_rd_idx + IW'(1);
                        n_state  = ST_READ;
                    end else begin
                        n_release = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_len        <= '0;
            r_cmd        <= '0;
            r_crc_low    <= '0;
            r_out_status <= STS_INCOMPLETE;
            r_out_last   <= 1'b0;
            r_release    <= 1'b0;
            r_rd_idx     <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_len        <= n_len;
            r_cmd        <= n_cmd;
            r_crc_low    <= n_crc_low;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
            r_release    <= n_release;
            r_rd_idx     <= n_rd_idx;
        end
    end

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_key  <= 16'd3;
            r_cfg_chal <= 16'd4;
            r_cfg_info <= 16'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PUBLIC_KEY: r_cfg_key  <= i_cfg_wdata;
                CFG_CHALLENGE:  r_cfg_chal <= i_cfg_wdata;
                CFG_INFO:       r_cfg_info <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Payload store with a registered read into the result register.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_idx] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_payload <= 8'h00;
        end else if (r_state == ST_READ) begin
            r_out_payload <= r_mem[r_rd_idx];
        end
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_SEND);
    assign o_status       = r_out_status;
    assign o_payload_byte = r_out_payload;
    assign o_last         = r_out_last;

    // A pending result always holds off new input.
    a_result_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall
    ) else $error("input not stalled while a result is pending");

    // An accepted byte stalls the input on the following cycle.
    a_accept_stalls: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall
    ) else $error("input not stalled after a request");

    // Only released payload results carry a nonzero byte.
    a_payload_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_release) |-> (o_payload_byte == 8'h00)
    ) else $error("nonzero payload outside a release run");

    // A release run ends exactly at the last stored entry.
    a_release_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_release && o_last) |-> (r_rd_idx == IW'(KEY_BYTES - 1))
    ) else $error("release run ended at the wrong entry");

    // The CRC shifter never starts while it is still shifting.
    a_crc_idle_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_crc_req.start |-> !w_crc_rsp.busy
    ) else $error("CRC shifter restarted while busy");

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cfr_pkg::*;

    localparam int KEY_BYTES     = 32;
    localparam int LONG_FRAME    = KEY_BYTES + 4;
    localparam int TARGET_ITEMS  = 360;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 80;
    localparam int DIRECTED_ROWS = 21;

    // How the byte value of a request is formed when it is sent.
    typedef enum logic [2:0] {
        K_DATA,
        K_CRC_LO,
        K_CRC_HI,
        K_CRC_BAD_LO,
        K_CRC_BAD_HI
    } t_byte_kind;

    typedef enum logic [2:0] {
        SHAPE_KEY,
        SHAPE_CHALLENGE,
        SHAPE_INFO,
        SHAPE_UNKNOWN,
        SHAPE_NOISE
    } t_frame_shape;

    // One byte request; for the bad CRC kinds, data holds the corruption mask.
    typedef struct packed {
        t_byte_kind kind;
        logic [7:0] data;
        logic       typed;
        logic [2:0] status;
    } t_frame_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload;
        logic       last;
    } t_frame_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_payload_byte;
    logic        o_last;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_PUBLIC_KEY;
    logic [15:0] i_cfg_wdata = 16'h0000;

    // Command registers as the block holds them.
    logic [15:0] cmd_public_key = 16'd3;
    logic [15:0] cmd_challenge  = 16'd4;
    logic [15:0] cmd_info       = 16'd8;

    // Frame state of the receiver.
    logic [5:0]  rx_count   = '0;
    logic [5:0]  rx_length  = '0;
    logic [15:0] rx_command = '0;
    logic [15:0] rx_crc     = CRC_INIT;
    logic [7:0]  rx_crc_low = '0;
    logic [7:0]  key_store [KEY_BYTES];

    t_frame_result step_results [KEY_BYTES];
    int            step_count;
    t_frame_result results_due [$];
    t_frame_req    frame_bytes [$];

    int error_count     = 0;
    int bytes_sent      = 0;
    int results_checked = 0;
    int settings_used   = 1;
    int status_tally [8];
    bit quiet_tx        = 1'b0;
    bit quiet_rx        = 1'b0;
    bit hold_request    = 1'b0;

    // Directed requests under the reset command codes: info frames with good
    // and broken CRC, and rejected command words.
    t_frame_req directed_rows [DIRECTED_ROWS] = '{
        '{K_DATA,       8'h08, 1'b1, STS_INCOMPLETE},
        '{K_DATA,       8'h00, 1'b1, STS_INCOMPLETE},
        '{K_DATA,       8'hFF, 1'b1, STS_INCOMPLETE},
        '{K_CRC_LO,     8'h00, 1'b1, STS_INCOMPLETE},
        '{K_CRC_HI,     8'h00, 1'b1, STS_INFO},
        '{K_DATA,       8'h08, 1'b0, STS_INCOMPLETE},
        '{K_DATA,       8'h00, 1'b0, STS_INCOMPLETE},
        '{K_DATA,       8'h00, 1'b0, STS_INCOMPLETE},
        '{K_CRC_LO,     8'h00, 1'b1, STS_INCOMPLETE},
        '{K_CRC_BAD_HI, 8'h01, 1'b1, STS_CRC_ERROR},
        '{K_DATA,       8'hFF, 1'b1, STS_INCOMPLETE},
        '{K_DATA,       8'hFF, 1'b1, STS_UNKNOWN},
        '{K_DATA,       8'h00, 1'b1, STS_INCOMPLETE},
        '{K_DATA,       8'h00, 1'b1, STS_UNKNOWN},
        '{K_DATA,       8'h00, 1'b1, STS_INCOMPLETE},
        '{K_DATA,       8'h03, 1'b1, STS_UNKNOWN},
        '{K_DATA,       8'h08, 1'b0, STS_INCOMPLETE},
        '{K_DATA,       8'h00, 1'b0, STS_INCOMPLETE},
        '{K_DATA,       8'h55, 1'b0, STS_INCOMPLETE},
        '{K_CRC_BAD_LO, 8'h80, 1'b1, STS_INCOMPLETE},
        '{K_CRC_HI,     8'h00, 1'b1, STS_CRC_ERROR}
    };

    command_frame_receiver_crc16 #(
        .KEY_BYTES(KEY_BYTES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_payload_byte(o_payload_byte),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // CRC-16/CCITT-FALSE, one byte, MSB first.
    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function void clear_rx_frame();
        rx_count   = '0;
        rx_length  = '0;
        rx_command = '0;
        rx_crc     = CRC_INIT;
        rx_crc_low = '0;
    endfunction

    function void post_status(input logic [2:0] st);
        step_results[0] = '{st, 8'h00, 1'b1};
        step_count      = 1;
    endfunction

    // Advances the frame state by one byte and leaves its results in step_results.
    function void take_frame_byte(input logic [7:0] b);
        logic [15:0] got;
        logic [15:0] cmd;
        logic        crc_ok;
        logic        long_frame;
        logic [2:0]  st;
        int          idx;
        step_count = 0;
        if (rx_length == 0) begin
            rx_crc = crc_ccitt_byte(rx_crc, b);
            if (rx_count == 0) begin
                rx_command = {8'h00, b};
                rx_count   = 6'd1;
                post_status(STS_INCOMPLETE);
            end else begin
                // The command word fixes the frame length once, here.
                rx_command[15:8] = b;
                if (rx_command == cmd_public_key || rx_command == cmd_challenge) begin
                    rx_length = 6'(LONG_FRAME);
                end else if (rx_command == cmd_info) begin
                    rx_length = 6'(SHORT_FRAME);
                end
                if (rx_length == 0) begin
                    clear_rx_frame();
                    post_status(STS_UNKNOWN);
                end else begin
                    rx_count = 6'd2;
                    post_status(STS_INCOMPLETE);
                end
            end
        end else if (int'(rx_count) + 2 < int'(rx_length)) begin
            idx = int'(rx_count) - 2;
            if (idx < KEY_BYTES) begin
                key_store[idx] = b;
            end
            rx_crc   = crc_ccitt_byte(rx_crc, b);
            rx_count = rx_count + 6'd1;
            post_status(STS_INCOMPLETE);
        end else if (int'(rx_count) + 2 == int'(rx_length)) begin
            rx_crc_low = b;
            rx_count   = rx_count + 6'd1;
            post_status(STS_INCOMPLETE);
        end else begin
            // Frame end: judge the word against the registers as they are now.
            got        = {b, rx_crc_low};
            crc_ok     = (got == rx_crc);
            long_frame = (rx_length == 6'(LONG_FRAME));
            cmd        = rx_command;
            clear_rx_frame();
            if (!crc_ok) begin
                post_status(STS_CRC_ERROR);
            end else if (long_frame && cmd == cmd_public_key) begin
                st = STS_KEY;
            end else if (long_frame && cmd == cmd_challenge) begin
                st = STS_CHALLENGE;
            end else if (cmd == cmd_info) begin
                post_status(STS_INFO);
            end else begin
                post_status(STS_UNKNOWN);
            end
            if (step_count == 0) begin
                for (int k = 0; k < KEY_BYTES; k++) begin
                    step_results[k] = '{st, key_store[k], (k == KEY_BYTES - 1)};
                end
                step_count = KEY_BYTES;
            end
        end
    endfunction

    // Mostly back to back, often a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 5);
    endfunction

    // Sends one request, waits for acceptance and records what it must cause.
    task send_frame_byte(input t_frame_req req);
        logic [7:0] value;
        int         gap;
        unique case (req.kind)
            K_CRC_LO:     value = rx_crc[7:0];
            K_CRC_HI:     value = rx_crc[15:8];
            K_CRC_BAD_LO: value = rx_crc[7:0] ^ req.data;
            K_CRC_BAD_HI: value = rx_crc[15:8] ^ req.data;
            default:      value = req.data;
        endcase
        gap = quiet_tx ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= value;
        do @(posedge i_clk); while (o_stall);
        take_frame_byte(value);
        if (req.typed) begin
            results_due.push_back(t_frame_result'{req.status, 8'h00, 1'b1});
        end else begin
            for (int k = 0; k < step_count; k++) begin
                results_due.push_back(step_results[k]);
            end
        end
        bytes_sent++;
    endtask

    task wait_for_results();
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_settings(input logic [15:0] pk, input logic [15:0] ch,
                        input logic [15:0] info);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PUBLIC_KEY;
        i_cfg_wdata <= pk;
        @(posedge i_clk);
        i_cfg_index <= CFG_CHALLENGE;
        i_cfg_wdata <= ch;
        @(posedge i_clk);
        i_cfg_index <= CFG_INFO;
        i_cfg_wdata <= info;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        cmd_public_key = pk;
        cmd_challenge  = ch;
        cmd_info       = info;
        settings_used++;
    endtask

    function void queue_byte(input t_byte_kind kind, input logic [7:0] data);
        frame_bytes.push_back(t_frame_req'{kind, data, 1'b0, STS_INCOMPLETE});
    endfunction

    // Builds a frame of the given shape; known shapes use the current command codes and get a CRC filled in when sent.
    function void make_frame(input t_frame_shape shape, input logic bad_crc);
        logic [15:0] cmd;
        int          n_payload;
        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(6, 1)) queue_byte(K_DATA, 8'($urandom));
            return;
        end
        if (shape == SHAPE_UNKNOWN) begin
            cmd = 16'($urandom);
        end else if (shape == SHAPE_KEY) begin
            cmd = cmd_public_key;
        end else if (shape == SHAPE_CHALLENGE) begin
            cmd = cmd_challenge;
        end else begin
            cmd = cmd_info;
        end
        queue_byte(K_DATA, cmd[7:0]);
        queue_byte(K_DATA, cmd[15:8]);
        if (shape == SHAPE_UNKNOWN) begin
            return;
        end
        n_payload = (shape == SHAPE_INFO) ? 1 : KEY_BYTES;
        repeat (n_payload) queue_byte(K_DATA, 8'($urandom));
        if (!bad_crc) begin
            queue_byte(K_CRC_LO, 8'h00);
            queue_byte(K_CRC_HI, 8'h00);
        end else if ($urandom_range(1) == 1) begin
            queue_byte(K_CRC_BAD_LO, 8'($urandom_range(255, 1)));
            queue_byte(K_CRC_HI, 8'h00);
        end else begin
            queue_byte(K_CRC_LO, 8'h00);
            queue_byte(K_CRC_BAD_HI, 8'($urandom_range(255, 1)));
        end
    endfunction

    // Mostly well-formed frames with random content, some broken ones and noise.
    task run_phase(input int n_items);
        int           pick;
        t_frame_shape shape;
        repeat (n_items) begin
            if (frame_bytes.size() == 0) begin
                pick = $urandom_range(99);
                if (pick < 34) begin
                    shape = SHAPE_KEY;
                end else if (pick < 58) begin
                    shape = SHAPE_CHALLENGE;
                end else if (pick < 78) begin
                    shape = SHAPE_INFO;
                end else if (pick < 88) begin
                    shape = SHAPE_UNKNOWN;
                end else begin
                    shape = SHAPE_NOISE;
                end
                make_frame(shape, $urandom_range(7) == 0);
            end
            if (!quiet_tx && $urandom_range(39) == 0) begin
                wait_for_results();
            end
            send_frame_byte(frame_bytes.pop_front());
        end
    endtask

    // Result side: random stall, quiet stretches and one long hold-off.
    initial begin
        int stall_len;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall_len = quiet_rx ? 0 : pick_gap();
                if (stall_len > 0) begin
                    i_stall <= 1'b1;
                    repeat (stall_len) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Every accepted result is matched against the oldest one due.
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $error("unexpected result: status %0d, payload 0x%02h, last %0d",
                       o_status, o_payload_byte, o_last);
                error_count++;
            end else begin
                want = results_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_payload_byte !== want.payload) begin
                    $error("payload_byte: expected 0x%02h, got 0x%02h",
                           want.payload, o_payload_byte);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    error_count++;
                end
                status_tally[want.status]++;
                results_checked++;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Timed out with %0d results still due.", results_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int phase;
        int phase_items;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset command codes.
        foreach (directed_rows[i]) begin
            send_frame_byte(directed_rows[i]);
        end
        wait_for_results();

        // Start the random part with one good frame of each released kind.
        make_frame(SHAPE_KEY, 1'b0);
        make_frame(SHAPE_CHALLENGE, 1'b0);

        // Phases may end mid-frame, so new codes also land inside a frame.
        phase = 0;
        while (bytes_sent < TARGET_ITEMS) begin
            quiet_tx = ($urandom_range(3) == 0);
            quiet_rx = ($urandom_range(3) == 0);
            if (phase == 3) begin
                quiet_tx     = 1'b1;
                hold_request = 1'b1;
            end
            phase_items = $urandom_range(70, 45);
            if (phase_items > TARGET_ITEMS - bytes_sent) begin
                phase_items = TARGET_ITEMS - bytes_sent;
            end
            run_phase(phase_items);
            wait_for_results();
            quiet_tx = 1'b0;
            quiet_rx = 1'b0;
            unique case (phase)
                0:       write_settings(16'h0000, 16'hFFFF, 16'h8001);
                1:       write_settings(16'hFFFF, 16'h0000, 16'h0000);
                2:       write_settings(16'h1234, 16'h1234, 16'h1234);
                3:       write_settings(16'($urandom), 16'($urandom), 16'($urandom));
                4:       write_settings(16'h00A5, 16'($urandom), 16'h00A5);
                default: write_settings(16'd3, 16'd4, 16'd8);
            endcase
            phase++;
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d bytes under %0d command settings.",
                 results_checked, bytes_sent, settings_used);
        $display("Frames: key %0d, challenge %0d, info %0d, unknown %0d, crc error %0d.",
                 status_tally[STS_KEY] / KEY_BYTES, status_tally[STS_CHALLENGE] / KEY_BYTES,
                 status_tally[STS_INFO], status_tally[STS_UNKNOWN],
                 status_tally[STS_CRC_ERROR]);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/cfr_pkg.sv
src/cfr_crc_unit.sv
src/command_frame_receiver_crc16.sv
sim/testbench.sv
